FILE: rtl/core/hpp_pkg.sv
// shared constants and types for the hpp lattice gas step block
package hpp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS  = X_BITS + Y_BITS;

    localparam int FUNC_BITS  = 2;
    localparam int COORD_BITS = 8;
    localparam int CELL_BITS  = 5;
    localparam int PART_BITS  = 4;
    localparam int DIM_BITS   = 9;
    localparam int PCNT_BITS  = 19;
    localparam int CCNT_BITS  = 17;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_STEP  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [CELL_BITS-1:0] WALL_CODE = 5'd16;
    localparam logic [PART_BITS-1:0] PAIR_NS   = 4'd5;
    localparam logic [PART_BITS-1:0] PAIR_EW   = 4'd10;

    localparam logic [DIM_BITS-1:0] MIN_DIM = 9'd3;
    localparam logic [DIM_BITS-1:0] MAX_W_DIM = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] MAX_H_DIM = DIM_BITS'(MAX_HEIGHT);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CELL_BITS-1:0] cell_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] r;
        if (v < MIN_DIM)
            r = MIN_DIM;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: rtl/core/hpp_ifs.sv
// channel interfaces: input items, results and configuration writes
interface hpp_item_if;
    import hpp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [FUNC_BITS-1:0]  func;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [CELL_BITS-1:0]  cell_value;
    modport source (output valid, func, cell_x, cell_y, cell_value, input ready);
    modport sink   (input valid, func, cell_x, cell_y, cell_value, output ready);
endinterface

interface hpp_result_if;
    import hpp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CELL_BITS-1:0] read_value;
    logic [PCNT_BITS-1:0] particle_count;
    logic [CCNT_BITS-1:0] collision_count;
    modport source (output valid, read_value, particle_count, collision_count, input ready);
    modport sink   (input valid, read_value, particle_count, collision_count, output ready);
endinterface

interface hpp_cfg_if;
    import hpp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [DIM_BITS-1:0]      data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/hpp_ram.sv
// generic single-write, single-read ram with registered read data
module hpp_ram #(
    parameter int AW = 16,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/hpp_lattice_gas_step.sv
// top level: hpp lattice gas automaton with two lattice banks and a reflection store
//
// channels: item (func, cell_x, cell_y, cell_value), result (read_value,
// particle_count, collision_count) and cfg (addr 0 grid_width, 1 grid_height).
// every item gives exactly one result beat; cfg is always ready and is to be written
// only while the block is idle, which the block itself does not enforce.
// after reset a clearing pass writes zero to every entry of both banks and of
// the reflection store, one address a cycle; no item is taken until it ends.
// a write or an unused func code goes from exec to finish, a read via a read state.
// a step walks the grid one cell at a time; each cell needs five reads of the
// current bank through its single read port, issued one after another in the
// phases of the cell.
// one item is worked on at a time. a new item is accepted while a result still
// waits; its result is held in the sequencer until the result register frees.
module hpp_lattice_gas_step (
    input  logic                clk,
    input  logic                rst_n,
    hpp_item_if.sink            item,
    hpp_result_if.source        result,
    hpp_cfg_if.sink             cfg
);
    import hpp_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_CELL   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [2:0] PH_LAST = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            phase_reg, phase_next;
    addr_t                 clr_reg, clr_next;
    logic                  bank_reg, bank_next;
    logic [DIM_BITS-1:0]   gw_reg, gh_reg;
    logic [FUNC_BITS-1:0]  func_reg;
    logic [COORD_BITS-1:0] ix_reg, iy_reg;
    cell_t                 ival_reg;
    logic [X_BITS-1:0]     x_reg, x_next;
    logic [Y_BITS-1:0]     y_reg, y_next;
    cell_t                 cen_reg, cen_next, nn_reg, nn_next, ee_reg, ee_next, ss_reg, ss_next;
    logic [PART_BITS-1:0]  pend_reg, pend_next;
    logic [PCNT_BITS-1:0]  parts_reg, parts_next;
    logic [CCNT_BITS-1:0]  cols_reg, cols_next;
    cell_t                 rd_reg, rd_next;
    logic                  ov_reg, ov_next;
    cell_t                 ord_reg;
    logic [PCNT_BITS-1:0]  opc_reg;
    logic [CCNT_BITS-1:0]  occ_reg;

    logic [DIM_BITS-1:0]   w_dim, h_dim, x9, y9, xp9, xm9, yp9, ym9;
    logic                  in_grid, last_x, last_y;
    addr_t                 raddr, waddr_cur, waddr_nxt;
    cell_t                 a_rdata, b_rdata, cur_rdata, cur_wdata, nxt_wdata;
    logic [PART_BITS-1:0]  pend_rdata, pend_wdata, v_arr, v_col, refl;
    logic                  a_we, b_we, pend_we, cur_we, nxt_we, is_col, out_free;
    addr_t                 pend_waddr;
    cell_t                 a_wdata, b_wdata;
    addr_t                 a_waddr, b_waddr;

    assign w_dim = clamp_dim(gw_reg, MAX_W_DIM);
    assign h_dim = clamp_dim(gh_reg, MAX_H_DIM);
    assign x9  = DIM_BITS'(x_reg);
    assign y9  = DIM_BITS'(y_reg);
    assign xp9 = (x9 + 9'd1 == w_dim) ? '0 : x9 + 9'd1;
    assign xm9 = (x9 == '0) ? w_dim - 9'd1 : x9 - 9'd1;
    assign yp9 = (y9 + 9'd1 == h_dim) ? '0 : y9 + 9'd1;
    assign ym9 = (y9 == '0) ? h_dim - 9'd1 : y9 - 9'd1;
    assign last_x = (x9 == w_dim - 9'd1);
    assign last_y = (y9 == h_dim - 9'd1);
    assign in_grid = (DIM_BITS'(ix_reg) < w_dim) && (DIM_BITS'(iy_reg) < h_dim);
    assign out_free = !ov_reg || result.ready;

    // current bank read address: item cell in exec, else centre or neighbor by phase
    always_comb
    begin
        raddr = {y_reg, x_reg};
        if (state_reg == ST_EXEC)
            raddr = {iy_reg[Y_BITS-1:0], ix_reg[X_BITS-1:0]};
        else
        begin
            unique case (phase_reg)
                3'd1:    raddr = {yp9[Y_BITS-1:0], x_reg};
                3'd2:    raddr = {y_reg, xp9[X_BITS-1:0]};
                3'd3:    raddr = {ym9[Y_BITS-1:0], x_reg};
                3'd4:    raddr = {y_reg, xm9[X_BITS-1:0]};
                default: raddr = {y_reg, x_reg};
            endcase
        end
    end

    assign cur_rdata = bank_reg ? b_rdata : a_rdata;

    // cell update, west neighbor arrives straight from the ram in the last phase
    always_comb
    begin
        v_arr = pend_reg | {cur_rdata[3], nn_reg[2], cen_reg[1] & 1'b0 | cur_rdata[1], ss_reg[0]};
        v_arr = pend_reg;
        v_arr[0] = v_arr[0] | ss_reg[0];
        v_arr[1] = v_arr[1] | cur_rdata[1];
        v_arr[2] = v_arr[2] | nn_reg[2];
        v_arr[3] = v_arr[3] | ee_reg[3];
        is_col = (v_arr == PAIR_NS) || (v_arr == PAIR_EW);
        v_col = is_col ? ~v_arr : v_arr;
        refl[2] = v_col[0] && (nn_reg == WALL_CODE);
        refl[3] = v_col[1] && (ee_reg == WALL_CODE);
        refl[0] = v_col[2] && (ss_reg == WALL_CODE);
        refl[1] = v_col[3] && (cur_rdata == WALL_CODE);
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        clr_next   = clr_reg;
        bank_next  = bank_reg;
        x_next = x_reg;
        y_next = y_reg;
        cen_next = cen_reg;
        nn_next = nn_reg;
        ee_next = ee_reg;
        ss_next = ss_reg;
        pend_next = pend_reg;
        parts_next = parts_reg;
        cols_next = cols_reg;
        rd_next = rd_reg;
        ov_next = ov_reg && !result.ready;
        cur_we = 1'b0;
        nxt_we = 1'b0;
        pend_we = 1'b0;
        waddr_cur = {iy_reg[Y_BITS-1:0], ix_reg[X_BITS-1:0]};
        waddr_nxt = {y_reg, x_reg};
        cur_wdata = ival_reg[4] ? WALL_CODE : {1'b0, ival_reg[3:0]};
        nxt_wdata = WALL_CODE;
        pend_waddr = waddr_cur;
        pend_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                parts_next = '0;
                cols_next = '0;
                rd_next = '0;
                x_next = '0;
                y_next = '0;
                phase_next = '0;
                state_next = ST_FINISH;
                if (func_reg == FUNC_WRITE)
                begin
                    cur_we = in_grid;
                    pend_we = in_grid;
                end
                else if (func_reg == FUNC_READ)
                    state_next = ST_READ;
                else if (func_reg == FUNC_STEP)
                    state_next = ST_CELL;
            end
            ST_READ:
            begin
                rd_next = in_grid ? cur_rdata : '0;
                state_next = ST_FINISH;
            end
            ST_CELL:
            begin
                phase_next = phase_reg + 3'd1;
                unique case (phase_reg)
                    3'd1:
                    begin
                        cen_next = cur_rdata;
                        pend_next = pend_rdata;
                    end
                    3'd2: nn_next = cur_rdata;
                    3'd3: ee_next = cur_rdata;
                    3'd4: ss_next = cur_rdata;
                    PH_LAST:
                    begin
                        nxt_we = 1'b1;
                        pend_we = 1'b1;
                        pend_waddr = {y_reg, x_reg};
                        if (cen_reg == WALL_CODE)
                        begin
                            nxt_wdata = WALL_CODE;
                            pend_wdata = '0;
                        end
                        else
                        begin
                            nxt_wdata = {1'b0, v_col};
                            pend_wdata = refl;
                            parts_next = parts_reg + PCNT_BITS'($countones(v_col));
                            cols_next = cols_reg + CCNT_BITS'(is_col);
                        end
                        phase_next = '0;
                        if (last_x)
                        begin
                            x_next = '0;
                            y_next = y_reg + 1'b1;
                            if (last_y)
                            begin
                                bank_next = !bank_reg;
                                state_next = ST_FINISH;
                            end
                        end
                        else
                            x_next = x_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_CLEAR)
        begin
            cur_we = 1'b0;
            nxt_we = 1'b0;
        end
    end

    // route the current and next bank ports, and the clearing pass
    always_comb
    begin
        a_we = 1'b0;
        b_we = 1'b0;
        a_waddr = waddr_cur;
        b_waddr = waddr_cur;
        a_wdata = cur_wdata;
        b_wdata = cur_wdata;
        if (state_reg == ST_CLEAR)
        begin
            a_we = 1'b1;
            b_we = 1'b1;
            a_waddr = clr_reg;
            b_waddr = clr_reg;
            a_wdata = '0;
            b_wdata = '0;
        end
        else if (cur_we)
        begin
            a_we = !bank_reg;
            b_we = bank_reg;
        end
        else if (nxt_we)
        begin
            a_we = bank_reg;
            b_we = !bank_reg;
            a_waddr = waddr_nxt;
            b_waddr = waddr_nxt;
            a_wdata = nxt_wdata;
            b_wdata = nxt_wdata;
        end
    end

    hpp_ram #(.AW(ADDR_BITS), .DW(CELL_BITS)) u_bank_a (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(raddr), .rdata(a_rdata)
    );

    hpp_ram #(.AW(ADDR_BITS), .DW(CELL_BITS)) u_bank_b (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(raddr), .rdata(b_rdata)
    );

    hpp_ram #(.AW(ADDR_BITS), .DW(PART_BITS)) u_reflect (
        .clk(clk),
        .we(pend_we || (state_reg == ST_CLEAR)),
        .waddr((state_reg == ST_CLEAR) ? clr_reg : pend_waddr),
        .wdata((state_reg == ST_CLEAR) ? '0 : pend_wdata),
        .raddr(raddr), .rdata(pend_rdata)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            phase_reg <= '0;
            clr_reg   <= '0;
            bank_reg  <= 1'b0;
            gw_reg    <= MAX_W_DIM;
            gh_reg    <= MAX_H_DIM;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            clr_reg   <= clr_next;
            bank_reg  <= bank_next;
            ov_reg    <= ov_next;
            if (cfg.valid && cfg.addr == REG_GRID_WIDTH)
                gw_reg <= cfg.data;
            if (cfg.valid && cfg.addr == REG_GRID_HEIGHT)
                gh_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            func_reg <= item.func;
            ix_reg   <= item.cell_x;
            iy_reg   <= item.cell_y;
            ival_reg <= item.cell_value;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        cen_reg <= cen_next;
        nn_reg <= nn_next;
        ee_reg <= ee_next;
        ss_reg <= ss_next;
        pend_reg <= pend_next;
        parts_reg <= parts_next;
        cols_reg <= cols_next;
        rd_reg <= rd_next;
        if (state_reg == ST_FINISH && out_free)
        begin
            ord_reg <= rd_reg;
            opc_reg <= parts_reg;
            occ_reg <= cols_reg;
        end
    end

    assign result.valid           = ov_reg;
    assign result.read_value      = ord_reg;
    assign result.particle_count  = opc_reg;
    assign result.collision_count = occ_reg;

    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat raised outside finish");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CELL |-> phase_reg <= PH_LAST)
        else $error("cell phase out of range");

    a_walk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CELL |-> (x9 < w_dim) && (y9 < h_dim))
        else $error("step walk left the grid");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> $past(state_reg) == ST_CELL)
        else $error("bank select flipped outside a step");
endmodule
